### rtl/nnat_pkg.sv
// Package for the node name/address table.
// Holds mode and status codes, the sequencer state type and the name check.
// No dependencies.
package nnat_pkg;

  localparam int unsigned NAME_W = 48;
  localparam int unsigned ADDR_W = 16;

  typedef enum logic [2:0] {
    MODE_SET       = 3'd0,
    MODE_REM_ADDR  = 3'd1,
    MODE_REM_NAME  = 3'd2,
    MODE_FIND_ADDR = 3'd3,
    MODE_FIND_NAME = 3'd4,
    MODE_NTH       = 3'd5,
    MODE_CLEAR     = 3'd6,
    MODE_UNUSED    = 3'd7
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_INVALID  = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_RANK,
    S_WRITE,
    S_DONE
  } state_t;

  // Uppercase and check a name; bit NAME_W of the result is the valid flag.
  function automatic logic [NAME_W:0] norm_name(input logic [NAME_W-1:0] chars,
                                                input logic [2:0] len);
    logic [NAME_W-1:0] acc;
    logic              ok;
    logic [7:0]        c;
    acc = '0;
    ok  = (len <= 3'd6);
    for (int i = 0; i < 6; i++) begin
      c = chars[8*i +: 8];
      if (3'(i) < len) begin
        if (c >= 8'h61 && c <= 8'h7A) c = c - 8'h20;
        else if (!((c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A))) ok = 1'b0;
        acc[8*i +: 8] = c;
      end
    end
    if (!ok) acc = '0;
    return {ok, acc};
  endfunction

endpackage

### rtl/nnat_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module nnat_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

### rtl/node_name_address_table.sv
// Node name/address table: top level with the scan sequencer.
// Uses nnat_pkg and nnat_ram (two RAM instances: addresses and names).
//
// One command is taken on a start pulse while busy is low; busy then stays
// high through the result strobe. Set, remove, find and n-th commands that
// pass the input checks sweep the slots through one shared compare unit,
// one slot per cycle behind the registered RAM read. Set, remove and find go
// through the sweep, a write-back state and the result state. Clear, the
// unused mode and commands rejected on their inputs alone (zero address, bad
// name, rank not below the entry count) answer in the cycle after the
// transfer. The n-th query tries candidate slots in slot order: an empty
// slot is skipped, a used one is read and then a counting sweep finds how
// many valid slots hold a lower address, until the candidate with the wanted
// rank turns up. The result sits on the output ports for exactly one cycle
// with done high; the receiver cannot stall it, so capture it then. Slot
// valid bits are cleared at reset; RAM contents are only used for valid
// slots.
module node_name_address_table
  import nnat_pkg::*;
#(
  parameter int unsigned TABLE_SLOTS = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [2:0]                    mode,
  input  logic [15:0]                   key_addr,
  input  logic [47:0]                   name_chars,
  input  logic [2:0]                    name_len,
  input  logic [5:0]                    rank_index,
  output logic                          done,
  output logic [1:0]                    status,
  output logic [15:0]                   out_addr,
  output logic [47:0]                   out_name,
  output logic [$clog2(TABLE_SLOTS+1)-1:0] entry_count
);
  localparam int unsigned IW = $clog2(TABLE_SLOTS);
  localparam int unsigned CW = $clog2(TABLE_SLOTS+1);

  state_t state, state_next;

  // command registers
  mode_t          cmd_mode;
  logic [15:0]    cmd_addr;
  logic [47:0]    cmd_name;
  logic [5:0]     cmd_rank;

  logic [TABLE_SLOTS-1:0] valid;
  logic [CW-1:0]          used;

  // scan: issue index drives RAM; check index is its registered copy
  logic [CW-1:0] rd_idx;
  logic [IW-1:0] chk_idx;
  logic          chk_live;

  // rank pass: candidate slot and its captured address
  logic [CW-1:0] cand;
  logic          cand_load;   // candidate read is issued this cycle
  logic [15:0]   cand_addr;
  logic [47:0]   cand_name;
  logic [CW-1:0] below;
  logic [CW-1:0] below_next;

  // scan findings
  logic          hit_addr, hit_name_other, have_free;
  logic [IW-1:0] addr_slot, name_slot, free_slot;
  logic [15:0]   name_slot_addr;
  logic [47:0]   addr_name;   // name of the slot matched by address

  // result registers
  status_t     res_status;
  logic [15:0] res_addr;
  logic [47:0] res_name;

  // RAM ports
  logic          ram_we;
  logic [IW-1:0] ram_a;
  logic [15:0]   ram_wa, rd_addr;
  logic [47:0]   ram_wn, rd_name;

  nnat_ram #(.WIDTH(16), .DEPTH(TABLE_SLOTS)) u_addr_ram (
    .clk(clk), .we(ram_we), .addr(ram_a), .wdata(ram_wa), .rdata(rd_addr));
  nnat_ram #(.WIDTH(48), .DEPTH(TABLE_SLOTS)) u_name_ram (
    .clk(clk), .we(ram_we), .addr(ram_a), .wdata(ram_wn), .rdata(rd_name));

  logic [48:0] nm_in;
  assign nm_in = norm_name(name_chars, name_len);

  logic pass_end;
  assign pass_end = chk_live && (chk_idx == IW'(TABLE_SLOTS-1));

  // Write target for set is chosen in S_WRITE
  logic          set_go;
  logic [IW-1:0] set_slot;
  always_comb begin
    set_go   = 1'b0;
    set_slot = free_slot;
    if (hit_addr) begin
      set_go = 1'b1; set_slot = addr_slot;
    end else if (have_free) begin
      set_go = 1'b1;
    end
  end

  // name already held by a slot of another address: drop the set
  logic name_clash;
  assign name_clash = hit_name_other && (name_slot_addr != cmd_addr);

  assign ram_we = (state == S_WRITE) && (cmd_mode == MODE_SET) && set_go && !name_clash;
  assign ram_a  = (state == S_WRITE) ? set_slot :
                  (state == S_RANK && cand_load) ? cand[IW-1:0] : rd_idx[IW-1:0];
  assign ram_wa = cmd_addr;
  assign ram_wn = cmd_name;

  // count including the slot checked this cycle
  assign below_next = below + CW'(valid[chk_idx] && (rd_addr < cand_addr));

  logic cand_hit;   // candidate has the wanted rank once the pass ends
  assign cand_hit = (below_next == CW'(cmd_rank));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (start) begin
        case (mode_t'(mode))
          MODE_CLEAR, MODE_UNUSED: state_next = S_DONE;
          MODE_SET: state_next = (key_addr == 16'd0 || !nm_in[48]) ? S_DONE : S_SCAN;
          MODE_REM_NAME, MODE_FIND_NAME:
            state_next = (!nm_in[48] || nm_in[47:0] == '0) ? S_DONE : S_SCAN;
          MODE_NTH: state_next = (CW'(rank_index) >= used) ? S_DONE : S_RANK;
          default: state_next = S_SCAN;
        endcase
      end
      S_SCAN:  if (pass_end) state_next = S_WRITE;
      S_RANK: begin
        if (pass_end && cand_hit) state_next = S_DONE;
        else if (!chk_live && cand == CW'(TABLE_SLOTS)) state_next = S_DONE;
      end
      S_WRITE: state_next = S_DONE;
      S_DONE:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy        = (state != S_IDLE);
    done        = (state == S_DONE);
    status      = res_status;
    out_addr    = done ? res_addr : 16'd0;
    out_name    = done ? res_name : 48'd0;
    entry_count = used;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      valid    <= '0;
      used     <= '0;
      chk_live <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: if (start) begin
          cmd_mode       <= mode_t'(mode);
          cmd_addr       <= key_addr;
          cmd_name       <= nm_in[47:0];
          cmd_rank       <= rank_index;
          rd_idx         <= '0;
          chk_live       <= 1'b0;
          cand           <= '0;
          cand_load      <= 1'b1;
          below          <= '0;
          hit_addr       <= 1'b0;
          hit_name_other <= 1'b0;
          have_free      <= 1'b0;
          res_addr       <= '0;
          res_name       <= '0;
          res_status     <= ST_OK;
          case (mode_t'(mode))
            MODE_CLEAR: begin
              valid <= '0; used <= '0;
            end
            MODE_UNUSED: res_status <= ST_INVALID;
            MODE_SET:
              if (key_addr == 16'd0 || !nm_in[48]) res_status <= ST_INVALID;
            MODE_REM_NAME, MODE_FIND_NAME:
              if (!nm_in[48] || nm_in[47:0] == '0) res_status <= ST_INVALID;
            MODE_NTH:
              if (CW'(rank_index) >= used) res_status <= ST_NOTFOUND;
            default: ;
          endcase
        end
        S_SCAN: begin
          // issue next read, check returned slot
          if (rd_idx != CW'(TABLE_SLOTS)) rd_idx <= rd_idx + CW'(1);
          chk_live <= (rd_idx != CW'(TABLE_SLOTS));
          chk_idx  <= rd_idx[IW-1:0];
          if (chk_live) begin
            if (valid[chk_idx]) begin
              if (rd_addr == cmd_addr && !hit_addr) begin
                hit_addr <= 1'b1; addr_slot <= chk_idx;
              end
              if (rd_name == cmd_name && cmd_name != '0 && !hit_name_other) begin
                name_slot      <= chk_idx;
                name_slot_addr <= rd_addr;
                hit_name_other <= 1'b1;
              end
            end else if (!have_free) begin
              have_free <= 1'b1; free_slot <= chk_idx;
            end
          end else if (rd_idx == '0) begin
            name_slot_addr <= 16'd0;
          end
        end
        S_RANK: begin
          // each pass: read slot 'cand', then count all slots below its address
          if (cand_load) begin
            chk_live <= 1'b0;
            below    <= '0;
            if (!valid[cand[IW-1:0]]) begin
              cand <= cand + CW'(1);
            end else begin
              cand_load <= 1'b0;
              rd_idx    <= '0;
            end
          end else if (!chk_live) begin
            // candidate data arrives now, slot 0 read is in flight
            cand_addr <= rd_addr;
            cand_name <= rd_name;
            rd_idx    <= CW'(1);
            chk_idx   <= '0;
            chk_live  <= 1'b1;
          end else begin
            if (rd_idx != CW'(TABLE_SLOTS)) rd_idx <= rd_idx + CW'(1);
            chk_idx <= rd_idx[IW-1:0];
            below   <= below_next;
            if (pass_end) begin
              chk_live <= 1'b0;
              if (cand_hit) begin
                res_addr <= cand_addr; res_name <= cand_name;
              end else begin
                cand      <= cand + CW'(1);
                cand_load <= 1'b1;
              end
            end
          end
        end
        S_WRITE: begin
          case (cmd_mode)
            MODE_SET: begin
              if (name_clash) begin
                res_status <= ST_INVALID;
              end else if (!set_go) begin
                res_status <= ST_FULL;
              end else if (!hit_addr) begin
                valid[free_slot] <= 1'b1;
                used <= used + CW'(1);
              end
            end
            MODE_REM_ADDR, MODE_REM_NAME: begin
              if (cmd_mode == MODE_REM_ADDR ? hit_addr : hit_name_other) begin
                valid[cmd_mode == MODE_REM_ADDR ? addr_slot : name_slot] <= 1'b0;
                used <= used - CW'(1);
              end else res_status <= ST_NOTFOUND;
            end
            MODE_FIND_ADDR: begin
              if (hit_addr) begin
                res_addr <= cmd_addr; res_name <= addr_name;
              end else res_status <= ST_NOTFOUND;
            end
            MODE_FIND_NAME: begin
              if (hit_name_other) begin
                res_addr <= name_slot_addr; res_name <= cmd_name;
              end else res_status <= ST_NOTFOUND;
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  // capture the name of the slot matched by address during the scan
  always_ff @(posedge clk) begin
    if (state == S_SCAN && chk_live && valid[chk_idx] && rd_addr == cmd_addr && !hit_addr)
      addr_name <= rd_name;
  end

  // Assertions
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    used <= CW'(TABLE_SLOTS)) else $error("entry count out of range");
  a_count_match: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> used == CW'($countones(valid))) else $error("count vs valid bits");
  a_done_one: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("result strobe longer than one cycle");
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("accepted command did not raise busy");
endmodule

### bench/node_name_address_table_tb.sv
// Self-checking bench for node_name_address_table: set/remove/find/nth/clear commands.
// Depends on nnat_pkg and the node_name_address_table RTL; compares every result strobe.
`timescale 1ns / 100ps

module node_name_address_table_tb
  import nnat_pkg::*;
();

  localparam int SLOTS       = 64;
  localparam int CYCLE_LIMIT = 40000000;

  typedef struct {
    logic [2:0]  mode;
    logic [15:0] key_addr;
    logic [47:0] name_chars;
    logic [2:0]  name_len;
    logic [5:0]  rank_index;
  } cmd_t;

  typedef struct {
    logic [1:0]  status;
    logic [15:0] addr;
    logic [47:0] name;
    logic [6:0]  count;
  } answer_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [2:0]  mode;
  logic [15:0] key_addr;
  logic [47:0] name_chars;
  logic [2:0]  name_len;
  logic [5:0]  rank_index;
  logic        done;
  logic [1:0]  status;
  logic [15:0] out_addr;
  logic [47:0] out_name;
  logic [6:0]  entry_count;

  node_name_address_table u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .mode(mode),
    .key_addr(key_addr), .name_chars(name_chars), .name_len(name_len),
    .rank_index(rank_index), .done(done), .status(status), .out_addr(out_addr),
    .out_name(out_name), .entry_count(entry_count)
  );

  // Shadow of the table contents.
  bit          tbl_valid [SLOTS];
  logic [15:0] tbl_addr  [SLOTS];
  logic [47:0] tbl_name  [SLOTS];
  int          tbl_used;

  cmd_t    pending_cmds[$];
  answer_t expected_answers[$];
  int      fail_count;
  int      cycle_count;
  int      gap_left;

  // Known addresses and names to steer random commands onto hits.
  logic [15:0] addr_pool[16];
  logic [47:0] name_pool[16];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit check_name(input logic [47:0] chars, input logic [2:0] len,
                                    output logic [47:0] norm);
    logic [7:0] c;
    norm = '0;
    if (len > 3'd6) return 1'b0;
    for (int i = 0; i < 6; i++) begin
      if (i < len) begin
        c = chars[8*i +: 8];
        if (c >= "a" && c <= "z") c = c - 8'd32;
        else if (!((c >= "0" && c <= "9") || (c >= "A" && c <= "Z"))) begin
          norm = '0;
          return 1'b0;
        end
        norm[8*i +: 8] = c;
      end
    end
    return 1'b1;
  endfunction

  function automatic int slot_of_addr(input logic [15:0] a);
    for (int i = 0; i < SLOTS; i++)
      if (tbl_valid[i] && tbl_addr[i] == a) return i;
    return -1;
  endfunction

  function automatic int slot_of_name(input logic [47:0] n);
    if (n == '0) return -1;
    for (int i = 0; i < SLOTS; i++)
      if (tbl_valid[i] && tbl_name[i] == n) return i;
    return -1;
  endfunction

  // Apply one command to the shadow table and return its answer.
  function automatic answer_t table_apply(input cmd_t c);
    answer_t     r;
    logic [47:0] nm;
    bit          ok;
    int          s;
    int          below;
    ok = check_name(c.name_chars, c.name_len, nm);
    r.status = ST_OK;
    r.addr   = '0;
    r.name   = '0;
    case (c.mode)
      MODE_SET: begin
        s = slot_of_name(nm);
        if (c.key_addr == 0 || !ok) r.status = ST_INVALID;
        else if (s >= 0 && tbl_addr[s] != c.key_addr) r.status = ST_INVALID;
        else begin
          s = slot_of_addr(c.key_addr);
          if (s >= 0) tbl_name[s] = nm;
          else begin
            r.status = ST_FULL;
            for (int i = 0; i < SLOTS; i++) begin
              if (!tbl_valid[i] && r.status == ST_FULL) begin
                tbl_valid[i] = 1'b1;
                tbl_addr[i]  = c.key_addr;
                tbl_name[i]  = nm;
                tbl_used++;
                r.status = ST_OK;
              end
            end
          end
        end
      end
      MODE_REM_ADDR, MODE_REM_NAME, MODE_FIND_ADDR, MODE_FIND_NAME: begin
        s = -1;
        if ((c.mode == MODE_REM_NAME || c.mode == MODE_FIND_NAME) && (!ok || nm == '0))
          r.status = ST_INVALID;
        else begin
          if (c.mode == MODE_REM_ADDR || c.mode == MODE_FIND_ADDR) s = slot_of_addr(c.key_addr);
          else s = slot_of_name(nm);
          if (s < 0) r.status = ST_NOTFOUND;
          else if (c.mode == MODE_REM_ADDR || c.mode == MODE_REM_NAME) begin
            tbl_valid[s] = 1'b0;
            tbl_used--;
          end else begin
            r.addr = tbl_addr[s];
            r.name = tbl_name[s];
          end
        end
      end
      MODE_NTH: begin
        r.status = ST_NOTFOUND;
        if (c.rank_index < tbl_used) begin
          for (int i = 0; i < SLOTS; i++) begin
            if (tbl_valid[i] && r.status == ST_NOTFOUND) begin
              below = 0;
              for (int j = 0; j < SLOTS; j++)
                if (tbl_valid[j] && tbl_addr[j] < tbl_addr[i]) below++;
              if (below == c.rank_index) begin
                r.status = ST_OK;
                r.addr   = tbl_addr[i];
                r.name   = tbl_name[i];
              end
            end
          end
        end
      end
      MODE_CLEAR: begin
        for (int i = 0; i < SLOTS; i++) tbl_valid[i] = 1'b0;
        tbl_used = 0;
      end
      default: r.status = ST_INVALID;
    endcase
    r.count = 7'(tbl_used);
    return r;
  endfunction

  function automatic logic [47:0] rand_name(input logic [2:0] len);
    logic [47:0] n;
    int          k;
    n = 48'({$urandom, $urandom});
    for (int i = 0; i < 6; i++) begin
      if (i < len) begin
        k = $urandom_range(0, 61);
        if (k < 10) n[8*i +: 8] = 8'("0" + k);
        else if (k < 36) n[8*i +: 8] = 8'("A" + k - 10);
        else n[8*i +: 8] = 8'("a" + k - 36);
      end
    end
    return n;
  endfunction

  function automatic cmd_t mk_cmd(input logic [2:0] m, input logic [15:0] a,
                                  input logic [47:0] n, input logic [2:0] l,
                                  input logic [5:0] r);
    cmd_t c;
    c.mode = m; c.key_addr = a; c.name_chars = n; c.name_len = l; c.rank_index = r;
    return c;
  endfunction

  // Random command: mostly well-formed against the pool, some noise.
  function automatic cmd_t rand_cmd();
    cmd_t c;
    int   p;
    p = $urandom_range(0, 99);
    c.mode       = (p < 35) ? MODE_SET : 3'($urandom_range(0, 7));
    if (c.mode == MODE_CLEAR && $urandom_range(0, 5) != 0) c.mode = MODE_FIND_ADDR;
    c.key_addr   = ($urandom_range(0, 9) < 8) ? addr_pool[$urandom_range(0, 15)]
                                              : 16'($urandom);
    c.name_len   = ($urandom_range(0, 9) < 8) ? 3'($urandom_range(0, 6)) : 3'($urandom);
    c.name_chars = rand_name(c.name_len);
    if ($urandom_range(0, 9) < 5) begin
      c.name_chars = name_pool[$urandom_range(0, 15)];
      c.name_len   = 3'd6;
    end
    if ($urandom_range(0, 19) == 0) c.name_chars = 48'({$urandom, $urandom});
    c.rank_index = ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(0, 20));
    return c;
  endfunction

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      tbl_valid[i] = 1'b0; tbl_addr[i] = '0; tbl_name[i] = '0;
    end
    tbl_used = 0;
    for (int i = 0; i < 16; i++) begin
      addr_pool[i] = 16'($urandom);
      name_pool[i] = rand_name(3'd6);
    end
    addr_pool[0] = 16'hFFFF;
    addr_pool[1] = 16'h0001;
    // Directed: extremes, each mode, name corner cases.
    pending_cmds.push_back(mk_cmd(MODE_NTH, 16'h0, 48'h0, 3'd0, 6'd0));
    pending_cmds.push_back(mk_cmd(MODE_SET, 16'h0, 48'h0, 3'd0, 6'd0));
    pending_cmds.push_back(mk_cmd(MODE_SET, 16'hFFFF, 48'h393061_7A5A41, 3'd6, 6'd0));
    pending_cmds.push_back(mk_cmd(MODE_SET, 16'h0001, 48'h0, 3'd0, 6'd0));
    pending_cmds.push_back(mk_cmd(MODE_SET, 16'h0002, 48'h393061_7A5A41, 3'd6, 6'd0));
    pending_cmds.push_back(mk_cmd(MODE_SET, 16'h0003, 48'h0000_0000_4100, 3'd2, 6'd0));
    pending_cmds.push_back(mk_cmd(MODE_SET, 16'h0003, 48'h4142_4344_4546, 3'd7, 6'd0));
    pending_cmds.push_back(mk_cmd(MODE_SET, 16'h0003, 48'hFFFF_FFFF_FF62, 3'd1, 6'd0));
    pending_cmds.push_back(mk_cmd(MODE_SET, 16'h0003, 48'h0000_0000_402F, 3'd1, 6'd0));
    pending_cmds.push_back(mk_cmd(MODE_SET, 16'h0001, 48'h0000_0000_0043, 3'd1, 6'd0));
    pending_cmds.push_back(mk_cmd(MODE_FIND_ADDR, 16'h0001, 48'h0, 3'd0, 6'd0));
    pending_cmds.push_back(mk_cmd(MODE_FIND_NAME, 16'h0, 48'h0000_0000_0063, 3'd1, 6'd0));
    pending_cmds.push_back(mk_cmd(MODE_FIND_NAME, 16'h0, 48'h0, 3'd0, 6'd0));
    pending_cmds.push_back(mk_cmd(MODE_NTH, 16'h0, 48'h0, 3'd0, 6'd2));
    pending_cmds.push_back(mk_cmd(MODE_NTH, 16'h0, 48'h0, 3'd0, 6'd63));
    pending_cmds.push_back(mk_cmd(MODE_REM_NAME, 16'h0, 48'h0000_0000_005B, 3'd1, 6'd0));
    pending_cmds.push_back(mk_cmd(MODE_REM_NAME, 16'h0, 48'h0000_0000_0043, 3'd1, 6'd0));
    pending_cmds.push_back(mk_cmd(MODE_REM_ADDR, 16'hFFFF, 48'h0, 3'd0, 6'd0));
    pending_cmds.push_back(mk_cmd(MODE_REM_ADDR, 16'hFFFF, 48'h0, 3'd0, 6'd0));
    pending_cmds.push_back(mk_cmd(MODE_UNUSED, 16'h0002, 48'h0, 3'd0, 6'd0));
    pending_cmds.push_back(mk_cmd(MODE_CLEAR, 16'h0, 48'h0, 3'd0, 6'd0));
    // Fill the table past full, then probe the deepest rank.
    for (int i = 1; i <= SLOTS + 2; i++)
      pending_cmds.push_back(mk_cmd(MODE_SET, 16'(i * 977), 48'h0, 3'd0, 6'd0));
    pending_cmds.push_back(mk_cmd(MODE_NTH, 16'h0, 48'h0, 3'd0, 6'd63));
    pending_cmds.push_back(mk_cmd(MODE_CLEAR, 16'h0, 48'h0, 3'd0, 6'd0));
    for (int i = 0; i < 1800; i++) pending_cmds.push_back(rand_cmd());
  end

  // Driver: hold start until the transfer, then idle a random gap.
  always @(posedge clk) begin
    if (rst) begin
      start    <= 1'b0;
      gap_left <= 0;
    end else if (start && !busy) begin
      start    <= 1'b0;
      gap_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 300)
                                              : $urandom_range(0, 3);
    end else if (!start) begin
      if (gap_left > 0) gap_left <= gap_left - 1;
      else if (pending_cmds.size() > 0) begin
        cmd_t c;
        c = pending_cmds.pop_front();
        expected_answers.push_back(table_apply(c));
        mode       <= c.mode;
        key_addr   <= c.key_addr;
        name_chars <= c.name_chars;
        name_len   <= c.name_len;
        rank_index <= c.rank_index;
        start      <= 1'b1;
      end
    end
  end

  // Monitor: compare each strobed result against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_answers.size() == 0) begin
        $error("result with nothing expected: status %0d", status);
        fail_count++;
      end else begin
        answer_t e;
        e = expected_answers.pop_front();
        if (status !== e.status) begin
          $error("status expected %0d actual %0d", e.status, status); fail_count++;
        end
        if (out_addr !== e.addr) begin
          $error("out_addr expected %h actual %h", e.addr, out_addr); fail_count++;
        end
        if (out_name !== e.name) begin
          $error("out_name expected %h actual %h", e.name, out_name); fail_count++;
        end
        if (entry_count !== e.count) begin
          $error("entry_count expected %0d actual %0d", e.count, entry_count);
          fail_count++;
        end
      end
    end
  end

  // Cycle watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    fail_count  = 0;
    cycle_count = 0;
    rst         = 1'b1;
    start       = 1'b0;
    mode        = '0;
    key_addr    = '0;
    name_chars  = '0;
    name_len    = '0;
    rank_index  = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    // Drain: every command handed over and every answer back.
    @(posedge clk);
    wait (pending_cmds.size() == 0 && !start && expected_answers.size() == 0);
    repeat (SLOTS * 4) @(posedge clk);
    if (fail_count == 0 && expected_answers.size() == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
